### rtl/chained_int_hash_map_unit_defines.svh
// Assertion macros for the chained hash map unit.
// Used by the top level only.
`ifndef CHAINED_INT_HASH_MAP_UNIT_DEFINES_SVH
`define CHAINED_INT_HASH_MAP_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CHM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CHM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/chm_pkg.sv
// Package for the chained hash map unit: codes, widths, command structs.
// No dependencies.
`default_nettype none
package chm_pkg;
    localparam int MAX_BUCKETS_DEF = 1024;
    localparam int POOL_NODES_DEF  = 4096;
    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 11'd1024;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_SET    = 2'd1;
    localparam logic [1:0] REQ_ACCUM  = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, start modulo
        logic mod_step;   // one restoring-division step
        logic head_rd;    // read bucket head and valid word
        logic node_rd;    // read node at walk index
        logic walk_adv;   // take link / head as walk index
        logic do_update;  // write value of found node
        logic do_insert;  // write new node and bucket head
        logic do_clear;   // restart the valid word sweep, empty the pool
        logic out_load;   // load result register
    } chm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mod_done;
        logic bkt_valid;
        logic walk_end;
        logic key_hit;
        logic pool_full;
        logic clr_done;   // valid sweep finished (after reset or clear)
        logic [1:0] req;
    } chm_sts_t;
endpackage
`default_nettype wire

### rtl/chm_if.sv
// Valid/ready stream interfaces for requests and results.
// Depends on nothing.
`default_nettype none
interface chm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] key;
    logic signed [31:0] operand_value;
    modport source (output valid, req_type, key, operand_value, input ready);
    modport sink (input valid, req_type, key, operand_value, output ready);
endinterface

interface chm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [31:0] result_value;
    modport source (output valid, status, result_value, input ready);
    modport sink (input valid, status, result_value, output ready);
endinterface
`default_nettype wire

### rtl/chm_datapath.sv
// Datapath: modulo unit, bucket and node memories, walk registers, result.
// Depends on chm_pkg.
`default_nettype none
module chm_datapath #(
    parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = chm_pkg::POOL_NODES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [chm_pkg::CFG_W-1:0] cfg_data,
    input  wire logic [1:0]  in_req,
    input  wire logic [31:0] in_key,
    input  wire logic [31:0] in_val,
    input  wire chm_pkg::chm_cmd_t cmd,
    output chm_pkg::chm_sts_t sts,
    output logic [2:0]  out_status,
    output logic [31:0] out_value
);
    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int NW = $clog2(POOL_NODES);
    localparam int UW = $clog2(POOL_NODES + 1);
    localparam int CW = $clog2(MAX_BUCKETS + 1);

    // config register, saturated on use
    logic [chm_pkg::CFG_W-1:0] bcount_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcount_reg <= chm_pkg::BUCKET_COUNT_RST;
        else if (cfg_we)
            bcount_reg <= cfg_data;
    end

    logic [CW-1:0] divisor;
    always_comb
    begin
        if (bcount_reg == '0)
            divisor = CW'(1);
        else if (32'(bcount_reg) > 32'(MAX_BUCKETS))
            divisor = CW'(MAX_BUCKETS);
        else
            divisor = CW'(bcount_reg);
    end

    // request registers
    logic [1:0]  req_reg;
    logic [31:0] key_reg, val_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_req;
            key_reg <= in_key;
            val_reg <= in_val;
        end
    end

    // restoring remainder, one key bit per step
    logic [CW:0]   rem_reg, rem_next, rem_sh;
    logic [5:0]    mcnt_reg;
    always_comb
    begin
        rem_sh = {rem_reg[CW-1:0], key_reg[31 - mcnt_reg[4:0]]};
        if (rem_sh >= {1'b0, divisor})
            rem_next = rem_sh - {1'b0, divisor};
        else
            rem_next = rem_sh;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.load)
        begin
            mcnt_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.mod_step)
        begin
            mcnt_reg <= mcnt_reg + 6'd1;
            rem_reg  <= rem_next;
        end
    end
    wire [BW-1:0] bucket = rem_reg[BW-1:0];

    // bucket valid bits, 32 to a memory word; one word zeroed per cycle
    // after reset and after a clear
    localparam int VWORDS = (MAX_BUCKETS + 31) / 32;
    localparam int VWW = (VWORDS > 1) ? $clog2(VWORDS) : 1;
    logic [31:0]   bvalid_mem [VWORDS];
    logic [31:0]   bvword_q;
    logic [VWW:0]  ccnt_reg;
    logic          sweep;
    wire [VWW-1:0] bword = VWW'(bucket >> 5);
    wire [4:0]     bbit  = 5'(bucket);

    assign sweep = (32'(ccnt_reg) < 32'(VWORDS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ccnt_reg <= '0;
        else if (cmd.do_clear)
            ccnt_reg <= '0;
        else if (sweep)
            ccnt_reg <= ccnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (sweep)
            bvalid_mem[ccnt_reg[VWW-1:0]] <= '0;
        else if (cmd.do_insert)
            bvalid_mem[bword] <= bvword_q | (32'd1 << bbit);
        if (cmd.head_rd)
            bvword_q <= bvalid_mem[bword];
    end

    // memories
    logic [NW-1:0] bhead_mem [MAX_BUCKETS];
    logic [31:0]   nkey_mem  [POOL_NODES];
    logic [31:0]   nval_mem  [POOL_NODES];
    logic [NW:0]   nlink_mem [POOL_NODES];
    logic [NW-1:0] head_q;
    logic [31:0]   nkey_q, nval_q;
    logic [NW:0]   nlink_q;
    logic [NW:0]   widx_reg;
    logic [UW-1:0] used_reg;
    logic          bv;
    logic [31:0]   newval;

    assign bv = bvword_q[bbit];
    assign newval = (req_reg == chm_pkg::REQ_SET) ? val_reg : nval_q + val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
            head_q <= bhead_mem[bucket];
        if (cmd.do_insert)
            bhead_mem[bucket] <= used_reg[NW-1:0];
    end
    always_ff @(posedge clk)
    begin
        if (cmd.node_rd)
        begin
            nkey_q  <= nkey_mem[widx_reg[NW-1:0]];
            nval_q  <= nval_mem[widx_reg[NW-1:0]];
            nlink_q <= nlink_mem[widx_reg[NW-1:0]];
        end
        if (cmd.do_insert)
        begin
            nkey_mem[used_reg[NW-1:0]]  <= key_reg;
            nval_mem[used_reg[NW-1:0]]  <= val_reg;
            nlink_mem[used_reg[NW-1:0]] <= bv ? {1'b0, head_q} : (NW+1)'(POOL_NODES);
        end
        else if (cmd.do_update)
            nval_mem[widx_reg[NW-1:0]] <= newval;
    end

    // walk index and step counter
    logic [UW-1:0] steps_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg  <= '0;
            steps_reg <= '0;
        end
        else if (cmd.head_rd)
            steps_reg <= '0;
        else if (cmd.walk_adv)
        begin
            if (steps_reg == '0)
                widx_reg <= {1'b0, head_q};
            else
                widx_reg <= nlink_q;
            steps_reg <= steps_reg + 1'b1;
        end
    end

    // pool fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else if (cmd.do_clear)
            used_reg <= '0;
        else if (cmd.do_insert)
            used_reg <= used_reg + 1'b1;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value <= '0;
            case (req_reg)
                chm_pkg::REQ_CLEAR:
                    out_status <= chm_pkg::ST_CLEARED;
                chm_pkg::REQ_LOOKUP:
                    if (sts.key_hit)
                    begin
                        out_status <= chm_pkg::ST_FOUND;
                        out_value  <= nval_q;
                    end
                    else
                        out_status <= chm_pkg::ST_MISSING;
                default:
                    if (sts.key_hit)
                    begin
                        out_status <= chm_pkg::ST_UPDATED;
                        out_value  <= newval;
                    end
                    else if (sts.pool_full)
                        out_status <= chm_pkg::ST_FULL;
                    else
                    begin
                        out_status <= chm_pkg::ST_INSERTED;
                        out_value  <= val_reg;
                    end
            endcase
        end
    end

    // status to controller; key_hit valid after node read of a live index
    logic hit_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (cmd.head_rd)
            hit_reg <= 1'b0;
        else if (cmd.walk_adv)
            hit_reg <= 1'b0;
        else if (cmd.node_rd)
            hit_reg <= 1'b1;
    end

    always_comb
    begin
        sts.req       = req_reg;
        sts.mod_done  = (mcnt_reg == 6'd32);
        sts.bkt_valid = bv;
        sts.walk_end  = (widx_reg >= (NW+1)'(POOL_NODES))
                        || (32'(steps_reg) > 32'(POOL_NODES));
        sts.key_hit   = hit_reg && (nkey_q == key_reg);
        sts.pool_full = (32'(used_reg) >= 32'(POOL_NODES));
        sts.clr_done  = !sweep;
    end
endmodule
`default_nettype wire

### rtl/chm_ctrl.sv
// Controller FSM sequencing modulo, chain walk, update and output.
// Depends on chm_pkg.
`default_nettype none
module chm_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  wire logic out_ready,
    input  wire chm_pkg::chm_sts_t sts,
    output chm_pkg::chm_cmd_t cmd
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_MOD   = 9'b000000100,
        S_HEAD  = 9'b000001000,
        S_ADV   = 9'b000010000,
        S_READ  = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_CLR   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    // result register parts the two sides; ready in idle only, after the sweep
    assign in_ready  = (state_reg == S_IDLE) && sts.clr_done;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd = '0;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DISP;
                end
            S_DISP:
                if (sts.req == chm_pkg::REQ_CLEAR)
                begin
                    cmd.do_clear = 1'b1;
                    state_next = S_CLR;
                end
                else
                    state_next = S_MOD;
            S_MOD:
                if (sts.mod_done)
                begin
                    cmd.head_rd = 1'b1;
                    state_next = S_HEAD;
                end
                else
                    cmd.mod_step = 1'b1;
            S_HEAD:
                state_next = sts.bkt_valid ? S_ADV : S_OUT;
            S_ADV:
            begin
                cmd.walk_adv = 1'b1;
                state_next = S_READ;
            end
            S_READ:
                if (sts.walk_end)
                    state_next = S_OUT;
                else
                begin
                    cmd.node_rd = 1'b1;
                    state_next = S_CMP;
                end
            S_CMP:
                state_next = sts.key_hit ? S_OUT : S_ADV;
            S_CLR:
                if (sts.clr_done)
                    state_next = S_OUT;
            S_OUT:
                // wait until the result register is free
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.req inside {chm_pkg::REQ_SET, chm_pkg::REQ_ACCUM})
                    begin
                        if (sts.key_hit)
                            cmd.do_update = 1'b1;
                        else if (!sts.pool_full)
                            cmd.do_insert = 1'b1;
                    end
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule
`default_nettype wire

### rtl/chained_int_hash_map_unit.sv
// Top level of the chained hash map unit: controller plus datapath.
// Depends on chm_pkg, chm_if, chm_ctrl, chm_datapath and the defines header.
//
// channel   dir  fields
// req       in   req_type[1:0], key[31:0], operand_value[31:0]
// rsp       out  status[2:0], result_value[31:0]
// cfg       in   cfg_we, cfg_data[10:0] (bucket_count)
//
// One request at a time: dispatch, 32 remainder steps (one key bit a cycle) and
// the head read, then an advance, a read and a compare per chain node visited,
// an advance and a read to reach the end of a chain on a miss, then the output step.
// Clear sweeps the bucket valid words 32 bits per cycle.
// After reset the same sweep runs with req.ready low.
// A stalled result holds only the output step; the next request is still taken.
`default_nettype none
`include "chained_int_hash_map_unit_defines.svh"
module chained_int_hash_map_unit #(
    parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = chm_pkg::POOL_NODES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    chm_req_if.sink   req,
    chm_rsp_if.source rsp,
    input  wire logic cfg_we,
    input  wire logic [chm_pkg::CFG_W-1:0] cfg_data
);
    chm_pkg::chm_cmd_t cmd;
    chm_pkg::chm_sts_t sts;

    chm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .sts(sts), .cmd(cmd)
    );

    chm_datapath #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_req(req.req_type), .in_key(req.key), .in_val(req.operand_value),
        .cmd(cmd), .sts(sts),
        .out_status(rsp.status), .out_value(rsp.result_value)
    );

    // checks
    `CHM_ASSERT_NEXT(a_accept_busy, clk, rst_n, req.valid && req.ready, !req.ready)
    `CHM_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.result_value))
    `CHM_ASSERT_IMPL(a_ins_upd_excl, clk, rst_n, cmd.do_insert, !cmd.do_update)
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for chained_int_hash_map_unit: drives lookup, set,
// accumulate and clear transactions and checks each result against a hash map predictor.
// Depends on chm_pkg, chm_if and the RTL of the unit.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT  = 1024;
    localparam int NPOOL = 4096;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] opv;
    } map_req_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] val;
    } map_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [chm_pkg::CFG_W-1:0] cfg_data = '0;

    chm_req_if req_ch();
    chm_rsp_if rsp_ch();

    chained_int_hash_map_unit dut (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    int unsigned bkt_count;
    bit          bkt_live [NBKT];
    int unsigned bkt_head [NBKT];
    logic [31:0] pool_key [NPOOL];
    logic [31:0] pool_val [NPOOL];
    int unsigned pool_link [NPOOL];
    int unsigned pool_used;

    map_req_t pending_reqs[$];
    map_rsp_t expected_rsps[$];
    logic [31:0] used_keys[$];
    int errors = 0;
    int cycles = 0;
    bit stim_done = 0;
    // set at the accepting rising edge, consumed at the next falling edge
    bit req_taken = 0;
    bit rsp_taken = 0;

    // compute the result of one request and update the map
    function automatic map_rsp_t hash_map_apply(map_req_t r);
        map_rsp_t o;
        int unsigned n, b, idx, hit, steps;
        n = bkt_count;
        if (n == 0) n = 1;
        if (n > NBKT) n = NBKT;
        o.val = '0;
        if (r.op == chm_pkg::REQ_CLEAR)
        begin
            foreach (bkt_live[i]) bkt_live[i] = 0;
            pool_used = 0;
            o.st = chm_pkg::ST_CLEARED;
            return o;
        end
        b = r.key % n;
        hit = NPOOL;
        if (bkt_live[b])
        begin
            idx = bkt_head[b];
            for (steps = 0; steps < NPOOL && idx < NPOOL; steps++)
            begin
                if (pool_key[idx] == r.key)
                begin
                    hit = idx;
                    break;
                end
                idx = pool_link[idx];
            end
        end
        if (r.op == chm_pkg::REQ_LOOKUP)
        begin
            o.st = (hit != NPOOL) ? chm_pkg::ST_FOUND : chm_pkg::ST_MISSING;
            if (hit != NPOOL) o.val = pool_val[hit];
        end
        else if (hit != NPOOL)
        begin
            pool_val[hit] = (r.op == chm_pkg::REQ_SET) ? r.opv : pool_val[hit] + r.opv;
            o.st = chm_pkg::ST_UPDATED;
            o.val = pool_val[hit];
        end
        else if (pool_used >= NPOOL)
            o.st = chm_pkg::ST_FULL;
        else
        begin
            idx = pool_used;
            pool_key[idx] = r.key;
            pool_val[idx] = r.opv;
            pool_link[idx] = bkt_live[b] ? bkt_head[b] : NPOOL;
            bkt_head[b] = idx;
            bkt_live[b] = 1;
            pool_used++;
            o.st = chm_pkg::ST_INSERTED;
            o.val = r.opv;
        end
        return o;
    endfunction

    // driver: one transaction per queued item, random gap after each accepted one
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                req_taken = 0;
                void'(pending_reqs.pop_front());
                req_ch.valid <= 1'b0;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            else if (!req_ch.valid && pending_reqs.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                else
                begin
                    req_ch.valid         <= 1'b1;
                    req_ch.req_type      <= pending_reqs[0].op;
                    req_ch.key           <= pending_reqs[0].key;
                    req_ch.operand_value <= pending_reqs[0].opv;
                end
            end
        end
    end

    // sink stall: ready pattern redrawn after each accepted result
    int recv_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                rsp_taken = 0;
                recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
                rsp_ch.ready <= (recv_gap == 0);
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_ch.ready <= (recv_gap == 0);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // monitor: predict on accepted requests, compare on accepted results
    always @(posedge clk)
    begin
        map_rsp_t got, want;
        cycles++;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            req_taken = 1;
            expected_rsps.push_back(hash_map_apply({req_ch.req_type, req_ch.key,
                                                    req_ch.operand_value}));
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_taken = 1;
            got = {rsp_ch.status, rsp_ch.result_value};
            if (expected_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual st=%0d val=%0d",
                         $time, got.st, $signed(got.val));
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (got.st !== want.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                end
                if (got.val !== want.val)
                begin
                    errors++;
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             $signed(want.val), $signed(got.val));
                end
            end
        end
        if (cycles > LIMIT)
        begin
            $display("chained_int_hash_map_unit verification failed");
            $finish;
        end
    end

    task automatic add_req(logic [1:0] op, logic [31:0] key, logic [31:0] opv);
        pending_reqs.push_back({op, key, opv});
    endtask

    // key from a small working set so chains form and hits are common
    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 5000) : $urandom;
        used_keys.push_back(k);
        return k;
    endfunction

    // wait until the block has drained, then write bucket_count
    task automatic drain_and_config(logic [chm_pkg::CFG_W-1:0] value);
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        bkt_count = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count, int fill_pool);
        logic [1:0] op;
        logic [31:0] v;
        for (int i = 0; i < count; i++)
        begin
            op = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 99) == 0) op = chm_pkg::REQ_CLEAR;
            v = $urandom_range(0, 3) == 0 ? 32'd1 : $urandom;
            if (fill_pool)
                add_req(chm_pkg::REQ_SET, $urandom, v);
            else
                add_req(op, pick_key(), v);
        end
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.req_type = chm_pkg::REQ_LOOKUP;
        req_ch.key = '0;
        req_ch.operand_value = '0;
        rsp_ch.ready = 1'b0;
        bkt_count = chm_pkg::BUCKET_COUNT_RST;
        pool_used = 0;
        foreach (bkt_live[i]) bkt_live[i] = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every operation, overflow wrap, chaining
        add_req(chm_pkg::REQ_LOOKUP, 32'd0, 32'd0);
        add_req(chm_pkg::REQ_SET, 32'd0, 32'h7FFF_FFFF);
        add_req(chm_pkg::REQ_ACCUM, 32'd0, 32'd1);
        add_req(chm_pkg::REQ_LOOKUP, 32'd0, 32'd0);
        add_req(chm_pkg::REQ_ACCUM, 32'hFFFF_FFFF, 32'h8000_0000);
        add_req(chm_pkg::REQ_ACCUM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(chm_pkg::REQ_SET, 32'hFFFF_FFFE, 32'hAAAA_5555);
        add_req(chm_pkg::REQ_SET, 32'd1024, 32'h5555_AAAA);
        add_req(chm_pkg::REQ_SET, 32'd2048, 32'd7);
        add_req(chm_pkg::REQ_LOOKUP, 32'd1024, 32'd0);
        add_req(chm_pkg::REQ_LOOKUP, 32'd3072, 32'd0);
        add_req(chm_pkg::REQ_ACCUM, 32'd2048, 32'd1);
        add_req(chm_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(chm_pkg::REQ_LOOKUP, 32'd1024, 32'd0);
        add_req(chm_pkg::REQ_SET, 32'd5, 32'd0);
        random_phase(120, 0);

        // single bucket: long chains
        drain_and_config(11'd1);
        add_req(chm_pkg::REQ_CLEAR, 32'd0, 32'd0);
        random_phase(60, 0);
        // zero, oversize and small bucket counts, map kept across the change
        drain_and_config(11'd0);
        random_phase(30, 0);
        drain_and_config(11'h7FF);
        random_phase(30, 0);
        drain_and_config(11'd1025);
        random_phase(20, 0);
        drain_and_config(11'd7);
        random_phase(60, 0);

        // full bucket range again after a clear
        drain_and_config(11'd1024);
        add_req(chm_pkg::REQ_CLEAR, 32'd0, 32'd0);
        add_req(chm_pkg::REQ_ACCUM, 32'h1234_5678, 32'd1);
        random_phase(40, 0);
        add_req(chm_pkg::REQ_CLEAR, 32'd0, 32'd0);
        drain_and_config(11'd1000);
        random_phase(90, 0);

        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        stim_done = 1;
    end

    // final verdict
    initial
    begin
        wait (stim_done);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("chained_int_hash_map_unit verification clean");
        else
            $display("chained_int_hash_map_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
